[src/sipq_pkg.sv]
package sipq_pkg;

	localparam int DEPTH     = 16;
	localparam int KEY_WIDTH = 32;
	localparam int CNT_W     = $clog2(DEPTH + 1);

	typedef logic [KEY_WIDTH-1:0] key_t;
	typedef logic [CNT_W-1:0]     count_t;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_POP    = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic operation;
		key_t key;
	} cmd_t;

	typedef struct packed {
		key_t    popped_key;
		logic    popped_valid;
		status_t status;
		count_t  occupancy;
	} res_t;

	// what a cell shows its right-hand neighbor
	typedef struct packed {
		key_t key;
		logic ge;
	} link_t;

endpackage

[src/sipq_cell.sv]
module sipq_cell (
	input  logic            clk,
	input  logic            upd,
	input  logic            is_pop,
	input  sipq_pkg::key_t  new_key,
	input  logic            occ,
	input  sipq_pkg::link_t left,
	input  sipq_pkg::key_t  right_key,
	output sipq_pkg::link_t link
);

	sipq_pkg::key_t key_q;
	sipq_pkg::key_t key_d;
	logic           ge;

	// an occupied stored key stays ahead of the new one when it is not smaller
	assign ge = occ && !(key_q < new_key);

	always_comb begin
		if (is_pop) begin
			key_d = right_key;
		end else if (ge) begin
			key_d = key_q;
		end else if (left.ge) begin
			key_d = new_key;
		end else begin
			key_d = left.key;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			key_q <= key_d;
		end
	end

	assign link.key = key_q;
	assign link.ge  = ge;

endmodule

[src/sorted_insert_priority_queue_core.sv]
// Channel | Dir | Handshake            | Word
// cmd     | in  | cmd_valid, cmd_stall | sipq_pkg::cmd_t: operation, key
// res     | out | res_valid, res_stall | sipq_pkg::res_t: popped_key, popped_valid,
//         |     |                      |   status, occupancy
//
// One word per cycle while cmd_stall is low: every cell compares its key and
// shifts in the same cycle, so the DEPTH cells take one insert or pop each clock.
// The result word is registered and shows up in the cycle after the command is accepted.
// Reset clears the key count and the result valid; stored keys are not cleared.
// cmd_stall is high only while a result word is held and res_stall is high.
module sorted_insert_priority_queue_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  sipq_pkg::cmd_t cmd,
	output logic           res_valid,
	input  logic           res_stall,
	output sipq_pkg::res_t res
);

	localparam int DEPTH = sipq_pkg::DEPTH;
	localparam int CNT_W = sipq_pkg::CNT_W;

	sipq_pkg::count_t  count_q;
	sipq_pkg::count_t  count_d;
	logic              res_valid_q;
	sipq_pkg::res_t    res_q;
	sipq_pkg::res_t    res_d;

	logic              acc;
	logic              is_pop;
	logic              empty;
	logic              full;
	logic              upd;

	sipq_pkg::link_t   link [DEPTH];
	logic [DEPTH-1:0]  occ;

	// accept whenever the result register is free or draining this cycle
	assign cmd_stall = res_valid_q && res_stall;
	assign acc       = cmd_valid && !cmd_stall;
	assign is_pop    = (cmd.operation == sipq_pkg::OP_POP);
	assign empty     = (count_q == '0);
	assign full      = (count_q == CNT_W'(DEPTH));
	// the row only moves on a pop with data or an insert with room
	assign upd       = acc && (is_pop ? !empty : !full);

	// cell row: cell 0 sees a left neighbor that is always ahead,
	// the last cell takes zero on a pop (it is beyond the count then)
	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			sipq_pkg::link_t left;
			sipq_pkg::key_t  right_key;

			assign occ[gi] = (CNT_W'(gi) < count_q);

			if (gi == 0) begin : g_head
				assign left.key = '0;
				assign left.ge  = 1'b1;
			end else begin : g_body
				assign left = link[gi-1];
			end

			if (gi == DEPTH - 1) begin : g_tail
				assign right_key = '0;
			end else begin : g_mid
				assign right_key = link[gi+1].key;
			end

			sipq_cell u_cell (
				.clk       (clk),
				.upd       (upd),
				.is_pop    (is_pop),
				.new_key   (cmd.key),
				.occ       (occ[gi]),
				.left      (left),
				.right_key (right_key),
				.link      (link[gi])
			);
		end
	endgenerate

	// result word and next count
	always_comb begin
		count_d            = count_q;
		res_d.popped_key   = '0;
		res_d.popped_valid = 1'b0;
		res_d.status       = sipq_pkg::ST_OK;
		if (is_pop) begin
			if (empty) begin
				res_d.status = sipq_pkg::ST_EMPTY;
			end else begin
				res_d.popped_key   = link[0].key;
				res_d.popped_valid = 1'b1;
				count_d            = count_q - CNT_W'(1);
			end
		end else begin
			if (full) begin
				res_d.status = sipq_pkg::ST_FULL;
			end else begin
				count_d = count_q + CNT_W'(1);
			end
		end
		res_d.occupancy = count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				count_q     <= count_d;
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// every accepted command leaves a result word behind
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> res_valid)
		else $error("no result after accepted command");

	// count stays within the row
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("key count beyond depth");

	// a pop returns a key no smaller than the new head
	a_pop_order: assert property (@(posedge clk) disable iff (!arst_n)
		acc && is_pop && (count_q > CNT_W'(1)) |=> res.popped_key >= link[0].key)
		else $error("popped key smaller than remaining head");

	// a dropped insert reports a full row
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status == sipq_pkg::ST_FULL) |-> res.occupancy == CNT_W'(DEPTH))
		else $error("full status with room left");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

	// generous ceiling: ~550 words, each at worst a full sender gap plus a full
	// receiver stall, two long hold-offs and the drain pauses, taken many times over
	localparam int unsigned LIMIT_CYCLES = 200_000;
	localparam int          RANDOM_WORDS = 530;
	localparam int          HOLD_CYCLES  = 120;

	typedef struct packed {
		logic           op;
		sipq_pkg::key_t key;
		logic           typed;
		sipq_pkg::res_t res;
	} drill_row_t;

	logic           clk       = 1'b0;
	logic           arst_n    = 1'b0;
	logic           cmd_valid = 1'b0;
	logic           cmd_stall;
	sipq_pkg::cmd_t cmd       = '0;
	logic           res_valid;
	logic           res_stall = 1'b0;
	sipq_pkg::res_t res;

	// hand-written expectation that travels with the word, valid on acceptance
	logic           row_typed = 1'b0;
	sipq_pkg::res_t row_res   = '0;

	// each increment asks the receiver for one long hold-off
	int hold_req = 0;

	sipq_pkg::key_t ranked_keys[$];     // predicted contents, largest first
	sipq_pkg::res_t pending_results[$]; // expected result words, oldest first
	int             errors     = 0;
	int             burst_left = 0;
	int unsigned    cycles     = 0;

	// Directed words. Rows with typed set carry a result that is obvious from
	// the queue contents; the rest are left to the predictor.
	drill_row_t drill [0:23] = '{
		// pop on an empty queue right after reset
		'{sipq_pkg::OP_POP, 32'h0000_0000, 1'b1,
			'{32'h0, 1'b0, sipq_pkg::ST_EMPTY, 5'd0}},
		'{sipq_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b1,
			'{32'h0, 1'b0, sipq_pkg::ST_OK, 5'd1}},
		'{sipq_pkg::OP_POP, 32'h0000_0000, 1'b1,
			'{32'hFFFF_FFFF, 1'b1, sipq_pkg::ST_OK, 5'd0}},
		// key field is ignored on a pop, even all ones
		'{sipq_pkg::OP_POP, 32'hFFFF_FFFF, 1'b1,
			'{32'h0, 1'b0, sipq_pkg::ST_EMPTY, 5'd0}},
		'{sipq_pkg::OP_INSERT, 32'h0000_0000, 1'b1,
			'{32'h0, 1'b0, sipq_pkg::ST_OK, 5'd1}},
		// fill up with extremes, alternating bits and repeated keys
		'{sipq_pkg::OP_INSERT, 32'h8000_0000, 1'b0, '0},
		'{sipq_pkg::OP_INSERT, 32'h7FFF_FFFF, 1'b0, '0},
		'{sipq_pkg::OP_INSERT, 32'h0000_0001, 1'b0, '0},
		'{sipq_pkg::OP_INSERT, 32'h0000_0005, 1'b0, '0},
		'{sipq_pkg::OP_INSERT, 32'h0000_0005, 1'b0, '0},
		'{sipq_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b0, '0},
		'{sipq_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b0, '0},
		'{sipq_pkg::OP_INSERT, 32'h5555_5555, 1'b0, '0},
		'{sipq_pkg::OP_INSERT, 32'hAAAA_AAAA, 1'b0, '0},
		'{sipq_pkg::OP_INSERT, 32'h0000_0000, 1'b0, '0},
		'{sipq_pkg::OP_INSERT, 32'h0000_0010, 1'b0, '0},
		'{sipq_pkg::OP_INSERT, 32'h1234_5678, 1'b0, '0},
		'{sipq_pkg::OP_INSERT, 32'hFFFF_FFFE, 1'b0, '0},
		'{sipq_pkg::OP_INSERT, 32'h0000_0005, 1'b0, '0},
		'{sipq_pkg::OP_INSERT, 32'h0000_0005, 1'b0, '0},
		// queue is full now: both inserts are dropped
		'{sipq_pkg::OP_INSERT, 32'h0001_2345, 1'b1,
			'{32'h0, 1'b0, sipq_pkg::ST_FULL, 5'd16}},
		'{sipq_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b1,
			'{32'h0, 1'b0, sipq_pkg::ST_FULL, 5'd16}},
		'{sipq_pkg::OP_POP,    32'h0000_0000, 1'b0, '0},
		'{sipq_pkg::OP_INSERT, 32'h0000_0000, 1'b0, '0}
	};

	sorted_insert_priority_queue_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Applies one command word to the predicted key list and returns the
	// result word it should produce. Ties go behind existing equal keys.
	function automatic sipq_pkg::res_t rank_and_report(input sipq_pkg::cmd_t w);
		sipq_pkg::res_t r;
		int             pos;
		r = '0;
		r.status = sipq_pkg::ST_OK;
		if (w.operation == sipq_pkg::OP_INSERT) begin
			if (ranked_keys.size() >= sipq_pkg::DEPTH) begin
				r.status = sipq_pkg::ST_FULL;
			end else begin
				pos = 0;
				while (pos < ranked_keys.size() && !(ranked_keys[pos] < w.key))
					pos++;
				ranked_keys.insert(pos, w.key);
			end
		end else if (ranked_keys.size() == 0) begin
			r.status = sipq_pkg::ST_EMPTY;
		end else begin
			r.popped_key   = ranked_keys.pop_front();
			r.popped_valid = 1'b1;
		end
		r.occupancy = sipq_pkg::count_t'(ranked_keys.size());
		return r;
	endfunction

	// Sampled at the edge, before any of this edge's updates land.
	// Results are checked before the new command is queued: a result can only
	// belong to a command taken on an earlier edge.
	always @(posedge clk) begin : check_results
		sipq_pkg::res_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (pending_results.size() == 0) begin
					$error("result word with nothing expected: %h", res);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (res.popped_key !== want.popped_key) begin
						$error("popped_key: expected %h, got %h",
							want.popped_key, res.popped_key);
						errors++;
					end
					if (res.popped_valid !== want.popped_valid) begin
						$error("popped_valid: expected %b, got %b",
							want.popped_valid, res.popped_valid);
						errors++;
					end
					if (res.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, res.status);
						errors++;
					end
					if (res.occupancy !== want.occupancy) begin
						$error("occupancy: expected %0d, got %0d",
							want.occupancy, res.occupancy);
						errors++;
					end
				end
			end
			if (cmd_valid && !cmd_stall) begin
				want = rank_and_report(cmd);
				if (row_typed)
					want = row_res;
				pending_results.insert(pending_results.size(), want);
			end
		end
	end

	// Receiver: a stall pattern of its own, switched after a random span,
	// plus long hold-offs on request so the core backs up into cmd_stall.
	initial begin : receiver
		int hold_seen;
		int mode;
		int span;
		int n;
		hold_seen = 0;
		forever begin
			if (hold_req != hold_seen) begin
				hold_seen++;
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(4, 40);
				for (n = 0; n < span && hold_req == hold_seen; n++) begin
					case (mode)
						0: res_stall <= 1'b0;
						1: res_stall <= $urandom_range(0, 1);
						2: res_stall <= (n % 5) < 3;          // stalls in runs, with gaps between
						default: res_stall <= ($urandom_range(0, 5) == 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// Offers one word and holds it until the core takes it. Called on an edge,
	// returns on the accepting edge, so back-to-back words keep valid high.
	task automatic put_word(input sipq_pkg::cmd_t w, input logic typed,
		input sipq_pkg::res_t typed_res);
		cmd       <= w;
		cmd_valid <= 1'b1;
		row_typed <= typed;
		row_res   <= typed_res;
		do @(posedge clk); while (cmd_stall);
	endtask

	// Bursts of random length with random gaps; a zero gap keeps valid high.
	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 20);
			gap = $urandom_range(0, 8);
			if (gap > 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Stop sending and wait until every expected result word has come back.
	task automatic drain_results();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	initial begin : sender
		sipq_pkg::cmd_t w;
		int             i;
		int             n;
		int             span;
		int             insert_pct;
		int             flood;
		int             sent;
		int             phase;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < $size(drill); i++) begin
			w.operation = drill[i].op;
			w.key       = drill[i].key;
			put_word(w, drill[i].typed, drill[i].res);
			pace_sender();
		end
		drain_results();

		// Random phases lean toward filling, draining or a balanced mix so the
		// queue keeps hitting both full and empty. Small keys give many ties.
		flood = 0;
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_WORDS) begin
			case ($urandom_range(0, 2))
				0: insert_pct = 85;
				1: insert_pct = 20;
				default: insert_pct = 55;
			endcase
			span = $urandom_range(20, 60);
			for (n = 0; n < span; n++) begin
				// long receiver hold-off while words keep coming with no gaps
				if (sent == 100 || sent == 380) begin
					hold_req <= hold_req + 1;
					flood = 40;
				end
				w.operation = ($urandom_range(0, 99) < insert_pct) ?
					sipq_pkg::OP_INSERT : sipq_pkg::OP_POP;
				case ($urandom_range(0, 9))
					0, 1, 2: w.key = sipq_pkg::key_t'($urandom_range(0, 15));
					3: w.key = $urandom_range(0, 1) ? '1 : '0;
					default: w.key = $urandom;
				endcase
				put_word(w, 1'b0, '0);
				sent++;
				if (flood > 0)
					flood--;
				else
					pace_sender();
			end
			phase++;
			if (phase % 4 == 0)
				drain_results();
		end

		drain_results();
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[files.f]
src/sipq_pkg.sv
src/sipq_cell.sv
src/sorted_insert_priority_queue_core.sv
sim/tb_top.sv
